[hdl/ccirc_pkg.sv]
// Shared constants and the result type for the circumcircle pipeline.
`timescale 1ns / 1ps

package ccirc_pkg;

	// Width of each result field.
	localparam int OUT_BITS = 41;
	// Fields in the result stream word.
	localparam int OUT_FIELDS = 3;
	// Result stream word, rounded up to whole bytes.
	localparam int OUT_TDATA_W = ((OUT_FIELDS * OUT_BITS + 7) / 8) * 8;

	// One entry of the output queue.
	typedef struct packed {
		logic                   collinear;
		logic [OUT_BITS-1:0]    radius;
		logic [OUT_BITS-1:0]    center_y;
		logic [OUT_BITS-1:0]    center_x;
	} result_t;

endpackage

[hdl/circumcircle_of_three_points.sv]
// Circumcircle of three integer points: fully pipelined, one request per cycle unless stalled.
//
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+-----------------
//  s_axis   | in  | tdata: ax, ay, bx, by, cx, cy            | tvalid / tready
//  m_axis   | out | tdata: center_x, center_y, radius; tuser | tvalid / tready
//           |     |        collinear                         |
//
// One request enters every cycle while the output queue has a free slot. The
// pipeline depth is set by the bit-per-stage square root followed by the
// bit-per-stage radius divider; the center dividers run beside the root.
// Reset empties the pipeline and the two-entry output queue. The whole
// pipeline advances while the output queue has a free slot, so a result that
// waits at the output does not block a new request from entering.
`timescale 1ns / 1ps

module circumcircle_of_three_points
	import ccirc_pkg::*;
#(
	parameter int COORD_BITS = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// ax, ay, bx, by, cx, cy, COORD_BITS each, from the lowest bit up
	input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// center_x, center_y, radius, 41 bits each, from the lowest bit up
	output logic [OUT_TDATA_W-1:0]        m_axis_tdata,
	// collinear
	output logic                          m_axis_tuser
);

	localparam int CB   = COORD_BITS;
	localparam int DFW  = CB + 1;          // coordinate difference
	localparam int PW   = 2*CB + 1;        // coordinate times difference
	localparam int DW   = 2*CB + 4;        // determinant
	localparam int SQRW = 2*CB;            // coordinate squared
	localparam int SAW  = 2*CB + 1;        // squared norm of a point
	localparam int NPW  = SAW + DFW;       // norm times difference
	localparam int NW   = 3*CB + 4;        // numerator
	localparam int EW   = 3*CB + 5;        // offset of A from center, scaled
	localparam int EM   = EW;              // its magnitude
	localparam int H    = (EM + 1) / 2;    // low half for the split square
	localparam int HI   = EM - H;          // high half
	localparam int SQW  = EM + 1;          // root and quotient width
	localparam int RW   = 2 * SQW;         // radicand width
	localparam int MW   = (SQW > OUT_BITS ? SQW : OUT_BITS) + 1;

	logic en;

	// ---------------------------------------------------------------
	// s1: unpack coordinates, form differences
	logic                  vld_s1;
	logic signed [CB-1:0]  ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [DFW-1:0] dyb_s1, dyc_s1, dya_s1, dxa_s1, dxb_s1, dxc_s1;

	logic signed [CB-1:0]  ax_in, ay_in, bx_in, by_in, cx_in, cy_in;
	assign ax_in = $signed(s_axis_tdata[0*CB +: CB]);
	assign ay_in = $signed(s_axis_tdata[1*CB +: CB]);
	assign bx_in = $signed(s_axis_tdata[2*CB +: CB]);
	assign by_in = $signed(s_axis_tdata[3*CB +: CB]);
	assign cx_in = $signed(s_axis_tdata[4*CB +: CB]);
	assign cy_in = $signed(s_axis_tdata[5*CB +: CB]);

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= ax_in;
			ay_s1  <= ay_in;
			bx_s1  <= bx_in;
			by_s1  <= by_in;
			cx_s1  <= cx_in;
			cy_s1  <= cy_in;
			dyb_s1 <= DFW'(by_in) - DFW'(cy_in);
			dyc_s1 <= DFW'(cy_in) - DFW'(ay_in);
			dya_s1 <= DFW'(ay_in) - DFW'(by_in);
			dxa_s1 <= DFW'(cx_in) - DFW'(bx_in);
			dxb_s1 <= DFW'(ax_in) - DFW'(cx_in);
			dxc_s1 <= DFW'(bx_in) - DFW'(ax_in);
		end
	end

	// ---------------------------------------------------------------
	// s2: determinant terms and coordinate squares
	logic                   vld_s2;
	logic signed [PW-1:0]   pa_s2, pb_s2, pc_s2;
	logic signed [SQRW-1:0] axx_s2, ayy_s2, bxx_s2, byy_s2, cxx_s2, cyy_s2;
	logic signed [CB-1:0]   ax_s2, ay_s2;
	logic signed [DFW-1:0]  dyb_s2, dyc_s2, dya_s2, dxa_s2, dxb_s2, dxc_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2  <= PW'(ax_s1) * PW'(dyb_s1);
			pb_s2  <= PW'(bx_s1) * PW'(dyc_s1);
			pc_s2  <= PW'(cx_s1) * PW'(dya_s1);
			axx_s2 <= SQRW'(ax_s1) * SQRW'(ax_s1);
			ayy_s2 <= SQRW'(ay_s1) * SQRW'(ay_s1);
			bxx_s2 <= SQRW'(bx_s1) * SQRW'(bx_s1);
			byy_s2 <= SQRW'(by_s1) * SQRW'(by_s1);
			cxx_s2 <= SQRW'(cx_s1) * SQRW'(cx_s1);
			cyy_s2 <= SQRW'(cy_s1) * SQRW'(cy_s1);
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			dyb_s2 <= dyb_s1;
			dyc_s2 <= dyc_s1;
			dya_s2 <= dya_s1;
			dxa_s2 <= dxa_s1;
			dxb_s2 <= dxb_s1;
			dxc_s2 <= dxc_s1;
		end
	end

	// ---------------------------------------------------------------
	// s3: determinant and squared norms
	logic                  vld_s3;
	logic signed [DW-1:0]  d_s3;
	logic signed [SAW-1:0] sa_s3, sb_s3, sc_s3;
	logic signed [CB-1:0]  ax_s3, ay_s3;
	logic signed [DFW-1:0] dyb_s3, dyc_s3, dya_s3, dxa_s3, dxb_s3, dxc_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3   <= (DW'(pa_s2) + DW'(pb_s2) + DW'(pc_s2)) <<< 1;
			sa_s3  <= SAW'(axx_s2) + SAW'(ayy_s2);
			sb_s3  <= SAW'(bxx_s2) + SAW'(byy_s2);
			sc_s3  <= SAW'(cxx_s2) + SAW'(cyy_s2);
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			dyb_s3 <= dyb_s2;
			dyc_s3 <= dyc_s2;
			dya_s3 <= dya_s2;
			dxa_s3 <= dxa_s2;
			dxb_s3 <= dxb_s2;
			dxc_s3 <= dxc_s2;
		end
	end

	// ---------------------------------------------------------------
	// s4: numerator terms and scaled coordinates of A
	logic                  vld_s4;
	logic signed [NPW-1:0] nxa_s4, nxb_s4, nxc_s4, nya_s4, nyb_s4, nyc_s4;
	logic signed [NW-1:0]  axd_s4, ayd_s4;
	logic signed [DW-1:0]  d_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			nxa_s4 <= NPW'(sa_s3) * NPW'(dyb_s3);
			nxb_s4 <= NPW'(sb_s3) * NPW'(dyc_s3);
			nxc_s4 <= NPW'(sc_s3) * NPW'(dya_s3);
			nya_s4 <= NPW'(sa_s3) * NPW'(dxa_s3);
			nyb_s4 <= NPW'(sb_s3) * NPW'(dxb_s3);
			nyc_s4 <= NPW'(sc_s3) * NPW'(dxc_s3);
			axd_s4 <= NW'(ax_s3) * NW'(d_s3);
			ayd_s4 <= NW'(ay_s3) * NW'(d_s3);
			d_s4   <= d_s3;
		end
	end

	// ---------------------------------------------------------------
	// s5: numerators
	logic                 vld_s5;
	logic signed [NW-1:0] nx_s5, ny_s5, axd_s5, ayd_s5;
	logic signed [DW-1:0] d_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s5  <= NW'(nxa_s4) + NW'(nxb_s4) + NW'(nxc_s4);
			ny_s5  <= NW'(nya_s4) + NW'(nyb_s4) + NW'(nyc_s4);
			axd_s5 <= axd_s4;
			ayd_s5 <= ayd_s4;
			d_s5   <= d_s4;
		end
	end

	// ---------------------------------------------------------------
	// s6: offsets from center, magnitudes and quotient signs
	logic                 vld_s6;
	logic [EM-1:0]        exm_s6, eym_s6;
	logic [NW-1:0]        nxm_s6, nym_s6;
	logic [DW-1:0]        dm_s6;
	logic                 negx_s6, negy_s6, zero_s6;

	logic signed [EW-1:0] ex_c, ey_c;
	assign ex_c = EW'(axd_s5) - EW'(nx_s5);
	assign ey_c = EW'(ayd_s5) - EW'(ny_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			exm_s6  <= ex_c[EW-1] ? EM'(-ex_c) : EM'(ex_c);
			eym_s6  <= ey_c[EW-1] ? EM'(-ey_c) : EM'(ey_c);
			nxm_s6  <= nx_s5[NW-1] ? NW'(-nx_s5) : NW'(nx_s5);
			nym_s6  <= ny_s5[NW-1] ? NW'(-ny_s5) : NW'(ny_s5);
			dm_s6   <= d_s5[DW-1] ? DW'(-d_s5) : DW'(d_s5);
			negx_s6 <= nx_s5[NW-1] ^ d_s5[DW-1];
			negy_s6 <= ny_s5[NW-1] ^ d_s5[DW-1];
			zero_s6 <= (d_s5 == '0);
		end
	end

	// ---------------------------------------------------------------
	// s7: split squares into half-width partial products
	logic                 vld_s7;
	logic [2*HI-1:0]      exhh_s7, eyhh_s7;
	logic [HI+H-1:0]      exhl_s7, eyhl_s7;
	logic [2*H-1:0]       exll_s7, eyll_s7;
	logic [NW-1:0]        nxm_s7, nym_s7;
	logic [DW-1:0]        dm_s7;
	logic                 negx_s7, negy_s7, zero_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			exhh_s7 <= (2*HI)'(exm_s6[EM-1:H]) * (2*HI)'(exm_s6[EM-1:H]);
			exhl_s7 <= (HI+H)'(exm_s6[EM-1:H]) * (HI+H)'(exm_s6[H-1:0]);
			exll_s7 <= (2*H)'(exm_s6[H-1:0]) * (2*H)'(exm_s6[H-1:0]);
			eyhh_s7 <= (2*HI)'(eym_s6[EM-1:H]) * (2*HI)'(eym_s6[EM-1:H]);
			eyhl_s7 <= (HI+H)'(eym_s6[EM-1:H]) * (HI+H)'(eym_s6[H-1:0]);
			eyll_s7 <= (2*H)'(eym_s6[H-1:0]) * (2*H)'(eym_s6[H-1:0]);
			nxm_s7  <= nxm_s6;
			nym_s7  <= nym_s6;
			dm_s7   <= dm_s6;
			negx_s7 <= negx_s6;
			negy_s7 <= negy_s6;
			zero_s7 <= zero_s6;
		end
	end

	// ---------------------------------------------------------------
	// s8: recombine each square
	logic                 vld_s8;
	logic [2*EM-1:0]      ex2_s8, ey2_s8;
	logic [NW-1:0]        nxm_s8, nym_s8;
	logic [DW-1:0]        dm_s8;
	logic                 negx_s8, negy_s8, zero_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			ex2_s8  <= ((2*EM)'(exhh_s7) << (2*H)) + ((2*EM)'(exhl_s7) << (H+1))
			           + (2*EM)'(exll_s7);
			ey2_s8  <= ((2*EM)'(eyhh_s7) << (2*H)) + ((2*EM)'(eyhl_s7) << (H+1))
			           + (2*EM)'(eyll_s7);
			nxm_s8  <= nxm_s7;
			nym_s8  <= nym_s7;
			dm_s8   <= dm_s7;
			negx_s8 <= negx_s7;
			negy_s8 <= negy_s7;
			zero_s8 <= zero_s7;
		end
	end

	// ---------------------------------------------------------------
	// s9: radicand, the squared scaled radius
	logic                 vld_s9;
	logic [RW-1:0]        rad_s9;
	logic [NW-1:0]        nxm_s9, nym_s9;
	logic [DW-1:0]        dm_s9;
	logic                 negx_s9, negy_s9, zero_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s9  <= RW'(ex2_s8) + RW'(ey2_s8);
			nxm_s9  <= nxm_s8;
			nym_s9  <= nym_s8;
			dm_s9   <= dm_s8;
			negx_s9 <= negx_s8;
			negy_s9 <= negy_s8;
			zero_s9 <= zero_s8;
		end
	end

	// ---------------------------------------------------------------
	// s10: square root and both center divisions, one bit per step
	logic           vld_s10  [SQW];
	logic [RW-1:0]  rad_s10  [SQW];
	logic [SQW-1:0] rem_s10  [SQW];
	logic [SQW-1:0] root_s10 [SQW];
	logic [SQW-1:0] xqn_s10  [SQW];
	logic [DW-1:0]  xrem_s10 [SQW];
	logic [SQW-1:0] yqn_s10  [SQW];
	logic [DW-1:0]  yrem_s10 [SQW];
	logic [DW-1:0]  dm_s10   [SQW];
	logic           negx_s10 [SQW];
	logic           negy_s10 [SQW];
	logic           zero_s10 [SQW];

	for (genvar j = 0; j < SQW; j++) begin : g_root
		logic           vin;
		logic [RW-1:0]  rad_i;
		logic [SQW-1:0] rem_i, root_i, xqn_i, yqn_i;
		logic [DW-1:0]  xrem_i, yrem_i, dm_i;
		logic           negx_i, negy_i, zero_i;
		logic [SQW+1:0] trial, tsub;
		logic           rge;
		logic [DW:0]    xtr, ytr;
		logic           xge, yge;

		if (j == 0) begin : g_first
			assign vin    = vld_s9;
			assign rad_i  = rad_s9;
			assign rem_i  = '0;
			assign root_i = '0;
			assign xqn_i  = SQW'(nxm_s9);
			assign xrem_i = '0;
			assign yqn_i  = SQW'(nym_s9);
			assign yrem_i = '0;
			assign dm_i   = dm_s9;
			assign negx_i = negx_s9;
			assign negy_i = negy_s9;
			assign zero_i = zero_s9;
		end else begin : g_next
			assign vin    = vld_s10[j-1];
			assign rad_i  = rad_s10[j-1];
			assign rem_i  = rem_s10[j-1];
			assign root_i = root_s10[j-1];
			assign xqn_i  = xqn_s10[j-1];
			assign xrem_i = xrem_s10[j-1];
			assign yqn_i  = yqn_s10[j-1];
			assign yrem_i = yrem_s10[j-1];
			assign dm_i   = dm_s10[j-1];
			assign negx_i = negx_s10[j-1];
			assign negy_i = negy_s10[j-1];
			assign zero_i = zero_s10[j-1];
		end

		// bring down two radicand bits, try the next root bit
		assign trial = {rem_i, rad_i[RW-1:RW-2]};
		assign tsub  = {root_i, 2'b01};
		assign rge   = (trial >= tsub);
		// bring down one dividend bit per center coordinate
		assign xtr   = {xrem_i, xqn_i[SQW-1]};
		assign ytr   = {yrem_i, yqn_i[SQW-1]};
		assign xge   = (xtr >= {1'b0, dm_i});
		assign yge   = (ytr >= {1'b0, dm_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s10[j] <= 1'b0;
			end else if (en) begin
				vld_s10[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s10[j]  <= rad_i << 2;
				rem_s10[j]  <= rge ? SQW'(trial - tsub) : SQW'(trial);
				root_s10[j] <= {root_i[SQW-2:0], rge};
				xrem_s10[j] <= xge ? DW'(xtr - {1'b0, dm_i}) : DW'(xtr);
				xqn_s10[j]  <= {xqn_i[SQW-2:0], xge};
				yrem_s10[j] <= yge ? DW'(ytr - {1'b0, dm_i}) : DW'(ytr);
				yqn_s10[j]  <= {yqn_i[SQW-2:0], yge};
				dm_s10[j]   <= dm_i;
				negx_s10[j] <= negx_i;
				negy_s10[j] <= negy_i;
				zero_s10[j] <= zero_i;
			end
		end
	end

	// ---------------------------------------------------------------
	// s11: divide the root by the determinant magnitude, one bit per step
	logic           vld_s11  [SQW];
	logic [SQW-1:0] rqn_s11  [SQW];
	logic [DW-1:0]  rrem_s11 [SQW];
	logic [SQW-1:0] xq_s11   [SQW];
	logic [SQW-1:0] yq_s11   [SQW];
	logic [DW-1:0]  dm_s11   [SQW];
	logic           negx_s11 [SQW];
	logic           negy_s11 [SQW];
	logic           zero_s11 [SQW];

	for (genvar j = 0; j < SQW; j++) begin : g_rdiv
		logic           vin;
		logic [SQW-1:0] rqn_i, xq_i, yq_i;
		logic [DW-1:0]  rrem_i, dm_i;
		logic           negx_i, negy_i, zero_i;
		logic [DW:0]    tr;
		logic           ge;

		if (j == 0) begin : g_first
			assign vin    = vld_s10[SQW-1];
			assign rqn_i  = root_s10[SQW-1];
			assign rrem_i = '0;
			assign xq_i   = xqn_s10[SQW-1];
			assign yq_i   = yqn_s10[SQW-1];
			assign dm_i   = dm_s10[SQW-1];
			assign negx_i = negx_s10[SQW-1];
			assign negy_i = negy_s10[SQW-1];
			assign zero_i = zero_s10[SQW-1];
		end else begin : g_next
			assign vin    = vld_s11[j-1];
			assign rqn_i  = rqn_s11[j-1];
			assign rrem_i = rrem_s11[j-1];
			assign xq_i   = xq_s11[j-1];
			assign yq_i   = yq_s11[j-1];
			assign dm_i   = dm_s11[j-1];
			assign negx_i = negx_s11[j-1];
			assign negy_i = negy_s11[j-1];
			assign zero_i = zero_s11[j-1];
		end

		assign tr = {rrem_i, rqn_i[SQW-1]};
		assign ge = (tr >= {1'b0, dm_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s11[j] <= 1'b0;
			end else if (en) begin
				vld_s11[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rrem_s11[j] <= ge ? DW'(tr - {1'b0, dm_i}) : DW'(tr);
				rqn_s11[j]  <= {rqn_i[SQW-2:0], ge};
				xq_s11[j]   <= xq_i;
				yq_s11[j]   <= yq_i;
				dm_s11[j]   <= dm_i;
				negx_s11[j] <= negx_i;
				negy_s11[j] <= negy_i;
				zero_s11[j] <= zero_i;
			end
		end
	end

	// ---------------------------------------------------------------
	// Apply sign and clamp a center quotient to the result range
	function automatic logic [OUT_BITS-1:0] clamp_center(
		input logic [SQW-1:0] q,
		input logic           neg
	);
		logic [MW-1:0] qw;
		logic [MW-1:0] lim;
		logic [OUT_BITS-1:0] r;
		qw  = MW'(q);
		lim = MW'(1) << (OUT_BITS - 1);
		if (neg) begin
			r = (qw > lim) ? OUT_BITS'(lim) : OUT_BITS'(-qw);
		end else begin
			r = (qw >= lim) ? OUT_BITS'(lim - MW'(1)) : OUT_BITS'(qw);
		end
		return r;
	endfunction

	// Clamp the radius quotient to the result range
	function automatic logic [OUT_BITS-1:0] clamp_radius(input logic [SQW-1:0] q);
		logic [MW-1:0] qw;
		logic [MW-1:0] lim;
		qw  = MW'(q);
		lim = (MW'(1) << OUT_BITS) - MW'(1);
		return (qw > lim) ? {OUT_BITS{1'b1}} : OUT_BITS'(qw);
	endfunction

	// ---------------------------------------------------------------
	// Final result; collinear points give all-zero fields
	result_t res_c;

	always_comb begin
		res_c = '0;
		if (zero_s11[SQW-1]) begin
			res_c.collinear = 1'b1;
		end else begin
			res_c.center_x = clamp_center(xq_s11[SQW-1], negx_s11[SQW-1]);
			res_c.center_y = clamp_center(yq_s11[SQW-1], negy_s11[SQW-1]);
			res_c.radius   = clamp_radius(rqn_s11[SQW-1]);
		end
	end

	// ---------------------------------------------------------------
	// Two-entry output queue; the pipeline advances while a slot is free
	result_t     fifo_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	assign en            = (cnt_q != 2'd2);
	assign s_axis_tready = en;
	assign push          = en & vld_s11[SQW-1];
	assign pop           = m_axis_tvalid & m_axis_tready;
	assign m_axis_tvalid = (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= res_c;
	end

	// Hold the early valid bits through stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// Drive the result stream from the queue head
	result_t head;
	assign head         = fifo_q[rd_ptr_q];
	assign m_axis_tuser = head.collinear;
	assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS*OUT_BITS){1'b0}},
	                       head.radius, head.center_y, head.center_x};

endmodule
